// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CHK_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define CHK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/htft_pkg.sv =====
// types, constants and codes for the histogram tail threshold unit
package htft_pkg;

  localparam int BINS_DEF       = 400;
  localparam int BIN_WIDTH_DEF  = 5;
  localparam int COUNT_BITS_DEF = 32;

  localparam int FRAC_BITS     = 32;
  localparam int VALUE_BITS    = 16;
  localparam int BIN_OUT_BITS  = 9;
  localparam int CENTER_BITS   = 12;
  localparam int ACC_OUT_BITS  = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [FRAC_BITS-1:0] KEEP_FRACTION_RESET = 32'd429497;

  localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_FRACTION = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_THRESHOLD = 2'd2;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [VALUE_BITS-1:0] sample_value;
    logic [VALUE_BITS-1:0] cut_value;
    logic                  random_pass;
  } sample_t;

  typedef struct packed {
    logic                    found;
    logic [BIN_OUT_BITS-1:0] threshold_bin;
    logic [CENTER_BITS-1:0]  threshold_center;
    logic [ACC_OUT_BITS-1:0] accepted_count;
  } result_t;

  typedef struct packed {
    logic add;
    logic load;
    logic mul_step;
    logic sweep;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic addr_zero;
    logic mul_last;
  } status_t;

endpackage

// ===== sv/htft_ctrl.sv =====
// controller state machine for the histogram tail threshold unit
`include "assert_macros.svh"

module htft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              opcode,
  input  htft_pkg::status_t status,
  output htft_pkg::cmd_t    cmd,
  output logic              busy
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.addr_zero) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (opcode == htft_pkg::OP_COMPUTE) begin
            cmd.load   = 1'b1;
            state_next = ST_MUL;
          end else begin
            cmd.add = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.sweep = 1'b1;
        cmd.scan  = 1'b1;
        if (status.addr_zero) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `CHK_CLK(a_busy_fall, $fell(busy) |-> ($past(state) == ST_DONE || $past(state) == ST_CLEAR), "busy dropped outside done or clear")

endmodule

// ===== sv/htft_dp.sv =====
// datapath: bin store, update pipeline, keep limit multiplier and tail scan
`include "assert_macros.svh"

module htft_dp #(
  parameter int BINS       = htft_pkg::BINS_DEF,
  parameter int BIN_WIDTH  = htft_pkg::BIN_WIDTH_DEF,
  parameter int COUNT_BITS = htft_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [htft_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [htft_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  htft_pkg::sample_t                    sample,
  input  htft_pkg::cmd_t                       cmd,
  output htft_pkg::status_t                    status,
  output htft_pkg::result_t                    result,
  output logic                                 result_valid
);

  localparam int FB  = htft_pkg::FRAC_BITS;
  localparam int VB  = htft_pkg::VALUE_BITS;
  localparam int IW  = $clog2(BINS);
  localparam int BW  = $clog2(BINS + 1);
  localparam int TW  = COUNT_BITS + IW + 1;
  localparam int PW  = COUNT_BITS + FB;
  localparam int MCW = $clog2(FB);
  localparam int QL  = $clog2(BIN_WIDTH);
  localparam int QS  = VB + QL;
  localparam int QPW = 2 * VB + 2;
  localparam longint QMUL = ((64'd1 << QS) + longint'(BIN_WIDTH) - 64'd1) / longint'(BIN_WIDTH);
  localparam longint RANGE = longint'(BINS) * longint'(BIN_WIDTH);
  localparam logic [IW-1:0] ADDR_TOP = IW'(BINS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [htft_pkg::CENTER_BITS-1:0] WIDTH_C = htft_pkg::CENTER_BITS'(BIN_WIDTH);

  logic [FB-1:0]         keep_fraction;
  logic                  cut_enable;
  logic [VB-1:0]         cut_threshold;
  logic [COUNT_BITS-1:0] acc_total;

  logic [COUNT_BITS-1:0] mem [BINS];
  logic [COUNT_BITS-1:0] rd;
  logic [IW-1:0]         raddr, waddr;
  logic                  we;
  logic [COUNT_BITS-1:0] wdata;

  logic                  pass, in_range;
  logic [QPW-1:0]        qprod, qsh;
  logic                  v1, v2, last_v;
  logic [IW-1:0]         idx1, idx2, last_idx;
  logic [COUNT_BITS-1:0] last_w, cur, newval;

  logic [IW-1:0]         addr;
  logic [MCW-1:0]        mulcnt;
  logic [FB-1:0]         fr;
  logic [PW-1:0]         prod;
  logic [COUNT_BITS-1:0] limit;
  logic [TW-1:0]         tail, tail_next;
  logic                  rd_v;
  logic [IW-1:0]         rd_idx;
  logic                  found;
  logic [BW-1:0]         bin_reg;
  logic [BW+11:0]        bin_ext;
  logic [htft_pkg::CENTER_BITS-1:0] bin_c, center;
  logic [COUNT_BITS+31:0] acc_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_fraction <= htft_pkg::KEEP_FRACTION_RESET;
      cut_enable    <= 1'b0;
      cut_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        htft_pkg::CFG_KEEP_FRACTION: keep_fraction <= cfg_data[FB-1:0];
        htft_pkg::CFG_CUT_ENABLE:    cut_enable    <= cfg_data[0];
        htft_pkg::CFG_CUT_THRESHOLD: cut_threshold <= cfg_data[VB-1:0];
        default: begin
        end
      endcase
    end
  end

  // sample acceptance and bin index by reciprocal multiply
  assign pass     = sample.random_pass && (!cut_enable || sample.cut_value >= cut_threshold);
  assign in_range = (64'(sample.sample_value) < 64'(RANGE));
  assign qprod    = QPW'(sample.sample_value) * QPW'(QMUL);
  assign qsh      = qprod >> QS;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_total <= '0;
    end else if (cmd.emit) begin
      acc_total <= '0;
    end else if (cmd.add && pass && acc_total != COUNT_MAX) begin
      acc_total <= acc_total + COUNT_BITS'(1);
    end
  end

  // bin update pipeline: index, read, increment and write
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      last_v <= 1'b0;
    end else begin
      v1 <= cmd.add && pass && in_range;
      v2 <= v1;
      if (cmd.sweep) begin
        last_v <= 1'b0;
      end else if (v2) begin
        last_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= qsh[IW-1:0];
    idx2 <= idx1;
    if (v2) begin
      last_idx <= idx2;
      last_w   <= newval;
    end
  end

  // forward the previous write when it hits the same bin
  assign cur    = (last_v && last_idx == idx2) ? last_w : rd;
  assign newval = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);

  assign raddr = cmd.sweep ? addr : idx1;
  assign waddr = cmd.sweep ? addr : idx2;
  assign we    = cmd.sweep || v2;
  assign wdata = cmd.sweep ? '0 : newval;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  // sweep address, multiplier counter, scan valid and found flag
  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= ADDR_TOP;
      mulcnt <= '0;
      rd_v   <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_v <= cmd.sweep && cmd.scan;
      if (cmd.load) begin
        addr <= ADDR_TOP;
      end else if (cmd.sweep && addr != '0) begin
        addr <= addr - IW'(1);
      end
      if (cmd.load) begin
        mulcnt <= MCW'(FB - 1);
      end else if (cmd.mul_step) begin
        mulcnt <= mulcnt - MCW'(1);
      end
      if (cmd.load) begin
        found <= 1'b0;
      end else if (rd_v && !found && tail_next > TW'(limit)) begin
        found <= 1'b1;
      end
    end
  end

  assign status.addr_zero = (addr == '0);
  assign status.mul_last  = (mulcnt == '0);

  // shift and add product of accepted total and keep fraction, msb first
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fr   <= keep_fraction;
      prod <= '0;
    end else if (cmd.mul_step) begin
      fr   <= fr << 1;
      prod <= (prod << 1) + (fr[FB-1] ? PW'(acc_total) : '0);
    end
  end

  assign limit     = prod[PW-1:FB];
  assign tail_next = tail + TW'(rd);

  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (cmd.load) begin
      tail <= '0;
    end else if (rd_v) begin
      tail <= tail_next;
    end
    if (rd_v && !found && tail_next > TW'(limit)) begin
      bin_reg <= BW'(rd_idx) + BW'(1);
    end
  end

  // result formatting
  assign bin_ext = (BW + 12)'(bin_reg);
  assign bin_c   = bin_ext[htft_pkg::CENTER_BITS-1:0];
  assign center  = htft_pkg::CENTER_BITS'(((bin_c << 1) - htft_pkg::CENTER_BITS'(1)) * WIDTH_C);
  assign acc_ext = (COUNT_BITS + 32)'(acc_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.found            <= found;
      result.threshold_bin    <= found ? bin_ext[htft_pkg::BIN_OUT_BITS-1:0] : '0;
      result.threshold_center <= found ? center : '0;
      result.accepted_count   <= acc_ext[htft_pkg::ACC_OUT_BITS-1:0];
    end
  end

  `CHK_NEVER(a_port_clash, cmd.sweep && v2, "bin update collides with sweep")
  `CHK_CLK(a_scan_drained, (cmd.sweep && cmd.scan) |-> (!v1 && !v2), "tail scan with updates in flight")
  `CHK_CLK(a_total_mono, !$past(cmd.emit) |-> (acc_total >= $past(acc_total)), "accepted total went down")

endmodule

// ===== sv/histogram_tail_fraction_threshold_unit.sv =====
// histogram tail threshold unit: add item keeps busy low, one item per cycle
// compute item: busy for a 32 step keep limit multiply, then a one bin per
// cycle scan that also zeroes the store; result strobe in the same cycle that busy falls
// reset: busy while the bin store is swept to zero, one bin per cycle
// results are shown for one cycle on result_valid; the receiver cannot stall
module histogram_tail_fraction_threshold_unit #(
  parameter int BINS       = htft_pkg::BINS_DEF,
  parameter int BIN_WIDTH  = htft_pkg::BIN_WIDTH_DEF,
  parameter int COUNT_BITS = htft_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  htft_pkg::sample_t                  sample,
  output htft_pkg::result_t                  result,
  output logic                               result_valid,
  input  logic                               cfg_we,
  input  logic [htft_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [htft_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  htft_pkg::cmd_t    cmd;
  htft_pkg::status_t status;

  htft_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (sample.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  htft_dp #(
    .BINS       (BINS),
    .BIN_WIDTH  (BIN_WIDTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== sim/htft_checker.sv =====
`timescale 1ns / 100ps
// result checker for the histogram tail threshold unit: tracks the histogram and checks each result
module htft_checker
  import htft_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  sample_t                  sample,
  input  result_t                  result,
  input  logic                     result_valid,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending
);

  localparam int NUM_BINS = BINS_DEF;
  localparam int BW       = BIN_WIDTH_DEF;
  localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

  logic [FRAC_BITS-1:0]      keep_frac;
  logic                      cut_on;
  logic [VALUE_BITS-1:0]     cut_min;
  logic [COUNT_BITS_DEF-1:0] bin_count [NUM_BINS];
  logic [COUNT_BITS_DEF-1:0] accepted;
  result_t                   threshold_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // highest bin whose upper tail exceeds accepted * keep fraction
  function automatic result_t find_threshold();
    result_t     r;
    logic [63:0] limit;
    logic [63:0] tail;
    r     = '0;
    limit = 64'(accepted) * 64'(keep_frac);
    limit = limit >> FRAC_BITS;
    tail  = '0;
    for (int i = NUM_BINS - 1; i >= 0; i--) begin
      if (!r.found) begin
        tail = tail + 64'(bin_count[i]);
        if (tail > limit) begin
          r.found            = 1'b1;
          r.threshold_bin    = BIN_OUT_BITS'(i + 1);
          r.threshold_center = CENTER_BITS'((2 * (i + 1) - 1) * BW);
        end
      end
    end
    r.accepted_count = ACC_OUT_BITS'(accepted);
    return r;
  endfunction

  function automatic void clear_histogram();
    for (int i = 0; i < NUM_BINS; i++) begin
      bin_count[i] = '0;
    end
    accepted = '0;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    int      idx;
    if (rst) begin
      keep_frac = KEEP_FRACTION_RESET;
      cut_on    = 1'b0;
      cut_min   = '0;
      clear_histogram();
      threshold_q.delete();
    end else begin
      if (result_valid) begin
        if (threshold_q.size() == 0) begin
          $error("result_valid with no result expected");
          fail_count++;
        end else begin
          want = threshold_q.pop_front();
          check_field("found", 32'(want.found), 32'(result.found));
          check_field("threshold_bin", 32'(want.threshold_bin), 32'(result.threshold_bin));
          check_field("threshold_center", 32'(want.threshold_center),
                      32'(result.threshold_center));
          check_field("accepted_count", want.accepted_count, result.accepted_count);
        end
      end
      if (start && !busy) begin
        if (sample.opcode == OP_COMPUTE) begin
          threshold_q.push_back(find_threshold());
          clear_histogram();
        end else if (sample.random_pass && (!cut_on || sample.cut_value >= cut_min)) begin
          if (accepted != COUNT_TOP) accepted = accepted + 1'b1;
          if (sample.sample_value < NUM_BINS * BW) begin
            idx = sample.sample_value / BW;
            if (bin_count[idx] != COUNT_TOP) bin_count[idx] = bin_count[idx] + 1'b1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEEP_FRACTION: keep_frac = cfg_data[FRAC_BITS-1:0];
          CFG_CUT_ENABLE:    cut_on    = cfg_data[0];
          CFG_CUT_THRESHOLD: cut_min   = cfg_data[VALUE_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending = threshold_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// testbench top: drives samples and register writes into the threshold unit and gives the verdict
module tb;
  import htft_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 82;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  sample_t                  sample;
  result_t                  result;
  logic                     result_valid;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       fail_count;
  int                       pending;
  int                       idle_cycles = 0;
  logic [VALUE_BITS-1:0]    cur_cut;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  histogram_tail_fraction_threshold_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .result       (result),
    .result_valid (result_valid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  htft_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .result       (result),
    .result_valid (result_valid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // watchdog: no item, result or register write for too long
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic sample_t mk_sample(logic op, logic [VALUE_BITS-1:0] sv,
                                        logic [VALUE_BITS-1:0] cv, logic rp);
    sample_t s;
    s.opcode       = op;
    s.sample_value = sv;
    s.cut_value    = cv;
    s.random_pass  = rp;
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // samples cluster around a center so that tails build up in a few bins
  function automatic sample_t random_add(int center);
    int r;
    int sv;
    int cv;
    r = $urandom_range(0, 99);
    if (r < 10) sv = $urandom_range(0, 65535);
    else if (r < 16) sv = (r < 13) ? $urandom_range(1995, 2004) : $urandom_range(0, 9);
    else sv = center + $urandom_range(0, 80);
    if ($urandom_range(0, 1) == 0) cv = $urandom_range(0, 65535);
    else cv = int'(cur_cut) + $urandom_range(0, 4) - 2;
    return mk_sample(OP_ADD, VALUE_BITS'(sv), VALUE_BITS'(cv), $urandom_range(0, 99) < 85);
  endfunction

  task automatic send(sample_t it);
    @(negedge clk);
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start  <= 1'b1;
    sample <= it;
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_CUT_THRESHOLD) cur_cut = val[VALUE_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int      sent;
    int      n;
    int      center;
    bit      steady;
    logic [FRAC_BITS-1:0] keep;
    rst       = 1'b1;
    start     = 1'b0;
    sample    = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_cut   = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);
    drain();

    // empty histogram, then edge values, overflow and a rejected sample
    send(mk_sample(OP_COMPUTE, 16'hFFFF, 16'hFFFF, 1'b1));
    send(mk_sample(OP_ADD, 16'd0, 16'd0, 1'b1));
    send(mk_sample(OP_ADD, 16'd1999, 16'd0, 1'b1));
    send(mk_sample(OP_ADD, 16'd2000, 16'd0, 1'b1));
    send(mk_sample(OP_ADD, 16'hFFFF, 16'hFFFF, 1'b1));
    send(mk_sample(OP_ADD, 16'd4, 16'hFFFF, 1'b0));
    send(mk_sample(OP_COMPUTE, 16'd0, 16'd0, 1'b0));
    // only an overflow sample
    send(mk_sample(OP_ADD, 16'd2000, 16'd0, 1'b1));
    send(mk_sample(OP_COMPUTE, 16'd0, 16'd0, 1'b0));
    drain();

    // full keep fraction, cut at its top
    write_reg(CFG_KEEP_FRACTION, 32'hFFFF_FFFF);
    write_reg(CFG_CUT_ENABLE, 32'd1);
    write_reg(CFG_CUT_THRESHOLD, 32'd65535);
    send(mk_sample(OP_ADD, 16'd5, 16'd65535, 1'b1));
    send(mk_sample(OP_ADD, 16'd10, 16'd65534, 1'b1));
    send(mk_sample(OP_ADD, 16'd1000, 16'd65535, 1'b1));
    send(mk_sample(OP_COMPUTE, 16'd0, 16'd0, 1'b0));
    drain();

    // zero keep fraction, cut enabled at zero
    write_reg(CFG_KEEP_FRACTION, 32'd0);
    write_reg(CFG_CUT_THRESHOLD, 32'd0);
    send(mk_sample(OP_ADD, 16'd7, 16'd0, 1'b1));
    send(mk_sample(OP_ADD, 16'd9, 16'd0, 1'b1));
    send(mk_sample(OP_COMPUTE, 16'd0, 16'd0, 1'b0));
    send(mk_sample(OP_COMPUTE, 16'd0, 16'd0, 1'b0));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: keep = 32'hFFFF_FFFF;
        1: keep = 32'd0;
        2: keep = 32'h8000_0000;
        3: keep = 32'h1999_999A;
        4: keep = KEEP_FRACTION_RESET;
        default: keep = $urandom();
      endcase
      write_reg(CFG_KEEP_FRACTION, keep);
      write_reg(CFG_CUT_ENABLE, CFG_DATA_BITS'(phase % 2));
      write_reg(CFG_CUT_THRESHOLD, (phase == 2) ? 32'd65535 : $urandom_range(0, 65535));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n      = $urandom_range(0, 14);
        center = $urandom_range(0, 1999);
        steady = ($urandom_range(0, 3) == 0);
        repeat (n) begin
          send(random_add(center));
          if (!steady) hold_off(pick_gap());
          sent++;
        end
        send(mk_sample(OP_COMPUTE, 16'($urandom()), 16'($urandom()), 1'($urandom())));
        sent++;
        if ($urandom_range(0, 9) == 0) drain();
        else hold_off(pick_gap());
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
